>>> hdl/color_key_centroid_macros.svh
// Assertion helpers for the color key centroid block.
// All of them sample on clk and are disabled while rst_n is low.
`ifndef COLOR_KEY_CENTROID_MACROS_SVH
`define COLOR_KEY_CENTROID_MACROS_SVH

// Same-cycle implication.
`define CKC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ckc assertion failed");

// Next-cycle implication.
`define CKC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ckc assertion failed");

`endif

>>> hdl/ckc_pkg.sv
package ckc_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 12;
    localparam int WID_W      = 13;
    localparam int CNT_W      = 25;
    localparam int SUM_W      = 37;
    localparam int QUO_W      = 12;
    localparam int STEP_W     = 4;
    localparam int CX_W       = 13;
    localparam int CY_W       = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int BOUND_W    = 24;
    localparam int ORG_W      = 12;

    localparam logic [WID_W-1:0] MAX_WIDTH   = 13'd4096;
    localparam logic [COL_W-1:0] ROW_MAX     = 12'd4095;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 25'h1FF_FFFF;
    localparam logic [CY_W-1:0]  Y_OFFSET    = 14'd22;
    localparam logic [STEP_W-1:0] LAST_STEP  = 4'd11;

    localparam logic [BOUND_W-1:0] LOWER_RESET = 24'h00_0000;
    localparam logic [BOUND_W-1:0] UPPER_RESET = 24'hFF_FFFF;
    localparam logic [WID_W-1:0]   WIDTH_RESET = 13'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_BOUND  = 3'd0,
        REG_UPPER_BOUND  = 3'd1,
        REG_MIN_COUNT    = 3'd2,
        REG_ORIGIN_X     = 3'd3,
        REG_ORIGIN_Y     = 3'd4,
        REG_REGION_WIDTH = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [BOUND_W-1:0] lower_bound;
        logic [BOUND_W-1:0] upper_bound;
        logic [CNT_W-1:0]   min_count;
        logic [ORG_W-1:0]   origin_x;
        logic [ORG_W-1:0]   origin_y;
        logic [WID_W-1:0]   region_width;
    } cfg_t;

    // One finished region, handed from the accumulator to the divider.
    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
    } job_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } qstat_t;

endpackage

>>> hdl/ckc_ifs.sv
interface ckc_pix_if;
    logic                       valid;
    logic                       ready;
    logic [ckc_pkg::PIX_W-1:0]  blue;
    logic [ckc_pkg::PIX_W-1:0]  green;
    logic [ckc_pkg::PIX_W-1:0]  red;
    logic                       last_pixel;

    modport source (output valid, blue, green, red, last_pixel, input ready);
    modport sink   (input valid, blue, green, red, last_pixel, output ready);
endinterface

interface ckc_res_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [ckc_pkg::CX_W-1:0]   center_x;
    logic [ckc_pkg::CY_W-1:0]   center_y;
    logic [ckc_pkg::CNT_W-1:0]  match_count;

    modport source (output valid, found, center_x, center_y, match_count, input ready);
    modport sink   (input valid, found, center_x, center_y, match_count, output ready);
endinterface

>>> hdl/ckc_front.sv
module ckc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ckc_pkg::cfg_t        cfg,
    input  ckc_pkg::qstat_t      qstat,
    ckc_pix_if.sink              pixel,
    output logic                 push,
    output ckc_pkg::job_t        push_job
);

    logic [ckc_pkg::COL_W-1:0] column_reg, column_next;
    logic [ckc_pkg::COL_W-1:0] row_reg, row_next;
    logic [ckc_pkg::CNT_W-1:0] count_reg, count_next, count_upd;
    logic [ckc_pkg::SUM_W-1:0] sum_x_reg, sum_x_next, sum_x_upd;
    logic [ckc_pkg::SUM_W-1:0] sum_y_reg, sum_y_next, sum_y_upd;
    logic [ckc_pkg::WID_W-1:0] eff_width;
    logic [ckc_pkg::WID_W-1:0] col_inc;
    logic                      accept;
    logic                      hit;

    assign pixel.ready = !qstat.full;
    assign accept      = pixel.valid && pixel.ready;

    always_comb
    begin
        hit = (pixel.blue  >= cfg.lower_bound[7:0])   && (pixel.blue  <= cfg.upper_bound[7:0])
           && (pixel.green >= cfg.lower_bound[15:8])  && (pixel.green <= cfg.upper_bound[15:8])
           && (pixel.red   >= cfg.lower_bound[23:16]) && (pixel.red   <= cfg.upper_bound[23:16])
           && (count_reg != ckc_pkg::COUNT_MAX);

        count_upd = count_reg;
        sum_x_upd = sum_x_reg;
        sum_y_upd = sum_y_reg;
        if (hit)
        begin
            count_upd = count_reg + ckc_pkg::CNT_W'(1);
            sum_x_upd = sum_x_reg + ckc_pkg::SUM_W'(column_reg);
            sum_y_upd = sum_y_reg + ckc_pkg::SUM_W'(row_reg);
        end

        // Clamp the row length into 1..MAX_WIDTH.
        if (cfg.region_width == '0)
            eff_width = ckc_pkg::WID_W'(1);
        else if (cfg.region_width > ckc_pkg::MAX_WIDTH)
            eff_width = ckc_pkg::MAX_WIDTH;
        else
            eff_width = cfg.region_width;

        col_inc = {1'b0, column_reg} + ckc_pkg::WID_W'(1);

        column_next = column_reg;
        row_next    = row_reg;
        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        if (accept)
        begin
            if (pixel.last_pixel)
            begin
                column_next = '0;
                row_next    = '0;
                count_next  = '0;
                sum_x_next  = '0;
                sum_y_next  = '0;
            end
            else
            begin
                count_next = count_upd;
                sum_x_next = sum_x_upd;
                sum_y_next = sum_y_upd;
                if (col_inc >= eff_width)
                begin
                    column_next = '0;
                    if (row_reg < ckc_pkg::ROW_MAX)
                        row_next = row_reg + ckc_pkg::COL_W'(1);
                end
                else
                begin
                    column_next = col_inc[ckc_pkg::COL_W-1:0];
                end
            end
        end
    end

    assign push           = accept && pixel.last_pixel;
    assign push_job.found = (count_upd > cfg.min_count) && (count_upd != '0);
    assign push_job.count = count_upd;
    assign push_job.sum_x = sum_x_upd;
    assign push_job.sum_y = sum_y_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            count_reg  <= count_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
        end
    end

endmodule

>>> hdl/ckc_queue.sv
module ckc_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ckc_pkg::job_t      push_job,
    input  logic               pop,
    output ckc_pkg::job_t      head,
    output ckc_pkg::qstat_t    qstat
);

    ckc_pkg::job_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push;
    logic       do_pop;

    assign qstat.not_empty = (fill_reg != 2'd0);
    assign qstat.full      = (fill_reg == 2'd2);
    assign do_push         = push && !qstat.full;
    assign do_pop          = pop && qstat.not_empty;
    assign head            = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> hdl/ckc_back.sv
module ckc_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  ckc_pkg::cfg_t      cfg,
    input  ckc_pkg::qstat_t    qstat,
    input  ckc_pkg::job_t      head,
    output logic               pop,
    ckc_res_if.source          result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    localparam int REM_W = ckc_pkg::CNT_W;
    localparam int Q_W   = ckc_pkg::QUO_W;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // The low word carries the remaining dividend bits out the top and takes
    // quotient bits in at the bottom.
    function automatic logic [REM_W+Q_W-1:0] div_step(
        input logic [REM_W-1:0] rem,
        input logic [Q_W-1:0]   low,
        input logic [REM_W-1:0] dvsr
    );
        logic [REM_W:0]   trial;
        logic [REM_W:0]   diff;
        logic [REM_W-1:0] rem_new;
        logic             qbit;
        trial = {rem, low[Q_W-1]};
        diff  = trial - {1'b0, dvsr};
        qbit  = (trial >= {1'b0, dvsr});
        rem_new = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
        return {rem_new, low[Q_W-2:0], qbit};
    endfunction

    state_t state_reg, state_next;
    logic [ckc_pkg::STEP_W-1:0] step_reg, step_next;
    logic [REM_W-1:0] rem_x_reg, rem_y_reg, dvsr_reg;
    logic [Q_W-1:0]   low_x_reg, low_y_reg;
    logic [REM_W+Q_W-1:0] nx, ny;

    logic                      found_reg;
    logic [ckc_pkg::CX_W-1:0]  cx_reg;
    logic [ckc_pkg::CY_W-1:0]  cy_reg;
    logic [ckc_pkg::CNT_W-1:0] mcount_reg;

    assign pop = (state_reg == ST_IDLE) && qstat.not_empty;

    assign nx = div_step(rem_x_reg, low_x_reg, dvsr_reg);
    assign ny = div_step(rem_y_reg, low_y_reg, dvsr_reg);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    step_next  = '0;
                    state_next = head.found ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + ckc_pkg::STEP_W'(1);
                if (step_reg == ckc_pkg::LAST_STEP)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (result.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Datapath: no reset needed.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            // Mean never exceeds the largest coordinate, so the upper dividend
            // bits are already below the divisor.
            rem_x_reg  <= head.sum_x[ckc_pkg::SUM_W-1:Q_W];
            low_x_reg  <= head.sum_x[Q_W-1:0];
            rem_y_reg  <= head.sum_y[ckc_pkg::SUM_W-1:Q_W];
            low_y_reg  <= head.sum_y[Q_W-1:0];
            dvsr_reg   <= head.count;
            found_reg  <= head.found;
            mcount_reg <= head.count;
            cx_reg     <= '0;
            cy_reg     <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_x_reg <= nx[REM_W+Q_W-1:Q_W];
            low_x_reg <= nx[Q_W-1:0];
            rem_y_reg <= ny[REM_W+Q_W-1:Q_W];
            low_y_reg <= ny[Q_W-1:0];
            if (step_reg == ckc_pkg::LAST_STEP)
            begin
                cx_reg <= {1'b0, cfg.origin_x} + {1'b0, nx[Q_W-1:0]};
                cy_reg <= {2'b0, cfg.origin_y} + {2'b0, ny[Q_W-1:0]} + ckc_pkg::Y_OFFSET;
            end
        end
    end

    assign result.valid       = (state_reg == ST_OUT);
    assign result.found       = found_reg;
    assign result.center_x    = cx_reg;
    assign result.center_y    = cy_reg;
    assign result.match_count = mcount_reg;

endmodule

>>> hdl/color_key_centroid.sv
// Color key centroid over one region of interest.
//
// pixel  : sink channel, one word per pixel (blue, green, red, last_pixel),
//          in raster order; last_pixel closes the region.
// result : source channel, one word per region: found, center_x, center_y,
//          match_count. Centers read 0 when the region is not found.
// cfg_*  : write port for bounds, min_count, origin and region width; write
//          only while no region is in flight.
//
// Throughput: one pixel per cycle while the two-entry region queue has room.
// After its last pixel is taken, a region waits in the queue until the divider
// is idle and takes it; a found region then runs 12 restoring divide steps,
// x and y means side by side, before its word appears; a region that is not
// found goes straight to the output word.
// The divider takes one region at a time, so closely spaced regions queue up
// and pixel.ready drops only while the queue is full.
// Reset clears the pixel counters, the queue and the divider, and loads the
// register defaults (full color band, width 640). A stalled result word is
// held until taken; pixels keep flowing until the queue fills behind it.
`include "color_key_centroid_macros.svh"

module color_key_centroid
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ckc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ckc_pkg::CFG_DATA_W-1:0]    cfg_data,
    ckc_pix_if.sink                           pixel,
    ckc_res_if.source                         result
);

    ckc_pkg::cfg_t   cfg_reg;
    ckc_pkg::qstat_t qstat;
    ckc_pkg::job_t   push_job;
    ckc_pkg::job_t   head;
    logic            push;
    logic            pop;

    // Register file; unknown indexes drop the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_bound  <= ckc_pkg::LOWER_RESET;
            cfg_reg.upper_bound  <= ckc_pkg::UPPER_RESET;
            cfg_reg.min_count    <= '0;
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.region_width <= ckc_pkg::WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ckc_pkg::REG_LOWER_BOUND:
                    cfg_reg.lower_bound  <= cfg_data[ckc_pkg::BOUND_W-1:0];
                ckc_pkg::REG_UPPER_BOUND:
                    cfg_reg.upper_bound  <= cfg_data[ckc_pkg::BOUND_W-1:0];
                ckc_pkg::REG_MIN_COUNT:
                    cfg_reg.min_count    <= cfg_data[ckc_pkg::CNT_W-1:0];
                ckc_pkg::REG_ORIGIN_X:
                    cfg_reg.origin_x     <= cfg_data[ckc_pkg::ORG_W-1:0];
                ckc_pkg::REG_ORIGIN_Y:
                    cfg_reg.origin_y     <= cfg_data[ckc_pkg::ORG_W-1:0];
                ckc_pkg::REG_REGION_WIDTH:
                    cfg_reg.region_width <= cfg_data[ckc_pkg::WID_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front: match and accumulate, hand off each closed region.
    ckc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .pixel    (pixel),
        .push     (push),
        .push_job (push_job)
    );

    // Decouple the pixel side from the divider.
    ckc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // Back: divide the sums and hold the result word.
    ckc_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .qstat  (qstat),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

    `CKC_ASSERT_IMPLY(a_not_found_zero, result.valid && !result.found,
        result.center_x == '0 && result.center_y == '0)
    `CKC_ASSERT_IMPLY(a_found_sane, result.valid && result.found,
        result.match_count != '0 && result.center_y >= ckc_pkg::Y_OFFSET)
    `CKC_ASSERT_NEXT(a_region_queued, pixel.valid && pixel.ready && pixel.last_pixel,
        qstat.not_empty || result.valid)

endmodule

>>> tb/color_key_centroid_test.sv
`timescale 1ns / 1ps

module color_key_centroid_test;

    // Limits of the tracking logic, as seen from the pins.
    localparam logic [ckc_pkg::WID_W-1:0] WIDTH_CEILING  = 13'd4096;
    localparam logic [ckc_pkg::COL_W-1:0] ROW_CEILING    = 12'd4095;
    localparam logic [ckc_pkg::CNT_W-1:0] COUNT_CEILING  = '1;
    localparam int                        CENTER_Y_BIAS  = 22;

    // Indexes past the register file; writes there must be dropped.
    localparam logic [ckc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [ckc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int RANDOM_PIXELS = 1500;
    localparam int DRAIN_CYCLES  = 16;     // divider latency plus slack
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic                      found;
        logic [ckc_pkg::CX_W-1:0]  center_x;
        logic [ckc_pkg::CY_W-1:0]  center_y;
        logic [ckc_pkg::CNT_W-1:0] match_count;
    } centroid_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIX} row_kind_t;

    typedef enum logic [1:0] {READY_ALWAYS, READY_DITHER, READY_SPARSE} ready_mode_t;

    // One line of the directed table: a register write or a pixel word.
    typedef struct {
        row_kind_t                      kind;
        logic [ckc_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [ckc_pkg::CFG_DATA_W-1:0] value;
        logic [ckc_pkg::PIX_W-1:0]      blue;
        logic [ckc_pkg::PIX_W-1:0]      green;
        logic [ckc_pkg::PIX_W-1:0]      red;
        logic                           closes;
        logic                           pinned;
        centroid_t                      want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [ckc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ckc_pkg::CFG_DATA_W-1:0] cfg_data;

    ckc_pix_if pixel_ch ();
    ckc_res_if result_ch ();

    color_key_centroid i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    // Register shadow, loaded with the reset defaults.
    logic [ckc_pkg::BOUND_W-1:0] key_lower     = '0;
    logic [ckc_pkg::BOUND_W-1:0] key_upper     = 24'hFF_FFFF;
    logic [ckc_pkg::CNT_W-1:0]   key_min_count = '0;
    logic [ckc_pkg::ORG_W-1:0]   key_origin_x  = '0;
    logic [ckc_pkg::ORG_W-1:0]   key_origin_y  = '0;
    logic [ckc_pkg::WID_W-1:0]   key_width     = 13'd640;

    // Region accumulators of the predictor.
    logic [ckc_pkg::COL_W-1:0] trk_col   = '0;
    logic [ckc_pkg::COL_W-1:0] trk_row   = '0;
    logic [ckc_pkg::CNT_W-1:0] trk_count = '0;
    logic [ckc_pkg::SUM_W-1:0] trk_sum_x = '0;
    logic [ckc_pkg::SUM_W-1:0] trk_sum_y = '0;

    centroid_t pending_centroids[$];
    stim_row_t directed_rows[$];

    // A typed-in expectation rides along with the pixel word that closes its region.
    logic      pin_armed = 1'b0;
    centroid_t pin_centroid = '0;

    int          mismatches   = 0;
    int          cycles       = 0;
    int          burst_left   = 0;
    int          gap_limit    = 0;
    ready_mode_t ready_mode   = READY_ALWAYS;
    logic [31:0] stall_bits   = '0;
    logic [4:0]  stall_slot   = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall on a pattern reloaded when the slot counter wraps; the sparse mode
    // gives ready about one cycle in eight, which makes the region queue back up.
    always @(negedge clk)
    begin
        if (stall_slot == '0)
            stall_bits = $urandom;
        case (ready_mode)
            READY_ALWAYS: result_ch.ready = 1'b1;
            READY_DITHER: result_ch.ready = stall_bits[stall_slot];
            default:      result_ch.ready = stall_bits[stall_slot]
                                          & stall_bits[stall_slot + 5'd9]
                                          & stall_bits[stall_slot + 5'd19];
        endcase
        stall_slot = stall_slot + 5'd1;
    end

    function automatic logic in_band(input logic [ckc_pkg::PIX_W-1:0] v, lo, hi);
        return v >= lo && v <= hi;
    endfunction

    function automatic void note_mismatch(input string what, input longint unsigned want,
                                          input longint unsigned got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    // Advance the predictor by one accepted pixel word; on the closing pixel
    // work out the centroid, queue it and clear the accumulators.
    function automatic void track_pixel(input logic [ckc_pkg::PIX_W-1:0] b, g, r,
                                        input logic closes);
        logic [ckc_pkg::WID_W-1:0] span;
        centroid_t                 centroid;
        span = key_width;
        if (span == '0)
            span = 13'd1;
        if (span > WIDTH_CEILING)
            span = WIDTH_CEILING;

        if (in_band(b, key_lower[7:0], key_upper[7:0])
            && in_band(g, key_lower[15:8], key_upper[15:8])
            && in_band(r, key_lower[23:16], key_upper[23:16])
            && trk_count < COUNT_CEILING)
        begin
            trk_count = trk_count + 1'b1;
            trk_sum_x = trk_sum_x + trk_col;
            trk_sum_y = trk_sum_y + trk_row;
        end

        if (!closes)
        begin
            // Wrap the column at the region width; the row sticks at its ceiling.
            if ({1'b0, trk_col} + 13'd1 >= span)
            begin
                trk_col = '0;
                if (trk_row < ROW_CEILING)
                    trk_row = trk_row + 1'b1;
            end
            else
                trk_col = trk_col + 1'b1;
            return;
        end

        centroid = '0;
        centroid.match_count = trk_count;
        if (trk_count > key_min_count && trk_count != '0)
        begin
            centroid.found    = 1'b1;
            centroid.center_x = ckc_pkg::CX_W'(key_origin_x + trk_sum_x / trk_count);
            centroid.center_y = ckc_pkg::CY_W'(key_origin_y + trk_sum_y / trk_count
                                               + CENTER_Y_BIAS);
        end
        pending_centroids.push_back(pin_armed ? pin_centroid : centroid);
        trk_col   = '0;
        trk_row   = '0;
        trk_count = '0;
        trk_sum_x = '0;
        trk_sum_y = '0;
    endfunction

    // Monitor: register writes, accepted pixels and accepted result words,
    // all sampled on the rising edge.
    always @(posedge clk)
    begin : monitor
        centroid_t want;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    ckc_pkg::REG_LOWER_BOUND:  key_lower     = cfg_data[ckc_pkg::BOUND_W-1:0];
                    ckc_pkg::REG_UPPER_BOUND:  key_upper     = cfg_data[ckc_pkg::BOUND_W-1:0];
                    ckc_pkg::REG_MIN_COUNT:    key_min_count = cfg_data[ckc_pkg::CNT_W-1:0];
                    ckc_pkg::REG_ORIGIN_X:     key_origin_x  = cfg_data[ckc_pkg::ORG_W-1:0];
                    ckc_pkg::REG_ORIGIN_Y:     key_origin_y  = cfg_data[ckc_pkg::ORG_W-1:0];
                    ckc_pkg::REG_REGION_WIDTH: key_width     = cfg_data[ckc_pkg::WID_W-1:0];
                    default: ;  // unused index: drop the write
                endcase
            end

            if (pixel_ch.valid && pixel_ch.ready)
                track_pixel(pixel_ch.blue, pixel_ch.green, pixel_ch.red, pixel_ch.last_pixel);

            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_centroids.size() == 0)
                    note_mismatch("result word with none pending, match_count",
                                  0, result_ch.match_count);
                else
                begin
                    want = pending_centroids.pop_front();
                    if (result_ch.found !== want.found)
                        note_mismatch("found", want.found, result_ch.found);
                    if (result_ch.center_x !== want.center_x)
                        note_mismatch("center_x", want.center_x, result_ch.center_x);
                    if (result_ch.center_y !== want.center_y)
                        note_mismatch("center_y", want.center_y, result_ch.center_y);
                    if (result_ch.match_count !== want.match_count)
                        note_mismatch("match_count", want.match_count, result_ch.match_count);
                end
            end
        end
    end

    // Drive one pixel word and hold it until taken. Bursts of random length
    // are separated by random gaps; a gap limit of 0 keeps the stream solid.
    task automatic send_pixel(input logic [ckc_pkg::PIX_W-1:0] b, g, r, input logic closes,
                              input logic pinned, input centroid_t want);
        int idle;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            idle = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
            if (idle != 0)
            begin
                pixel_ch.valid = 1'b0;
                repeat (idle) @(negedge clk);
            end
        end
        burst_left--;
        pixel_ch.valid      = 1'b1;
        pixel_ch.blue       = b;
        pixel_ch.green      = g;
        pixel_ch.red        = r;
        pixel_ch.last_pixel = closes;
        pin_armed           = pinned;
        pin_centroid        = want;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        @(negedge clk);
    endtask

    // Pick a channel value around the current band: inside, on either bound,
    // just outside, or anywhere.
    function automatic logic [ckc_pkg::PIX_W-1:0] pick_level(
        input logic [ckc_pkg::PIX_W-1:0] lo, hi);
        case ($urandom_range(0, 7))
            0, 1, 2: return (lo <= hi) ? ckc_pkg::PIX_W'($urandom_range(lo, hi))
                                       : ckc_pkg::PIX_W'($urandom);
            3:       return lo;
            4:       return hi;
            5:       return lo - 8'd1;
            6:       return hi + 8'd1;
            default: return ckc_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_region(input int pixels);
        for (int k = 0; k < pixels; k++)
            send_pixel(pick_level(key_lower[7:0], key_upper[7:0]),
                       pick_level(key_lower[15:8], key_upper[15:8]),
                       pick_level(key_lower[23:16], key_upper[23:16]),
                       k == pixels - 1, 1'b0, '0);
    endtask

    // Drop valid, wait for every pending result word, then let the divider
    // drain before anything touches the registers.
    task automatic settle_block();
        pixel_ch.valid = 1'b0;
        while (pending_centroids.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [ckc_pkg::CFG_IDX_W-1:0] reg_index,
                             input logic [ckc_pkg::CFG_DATA_W-1:0] value);
        pixel_ch.valid = 1'b0;
        cfg_write      = 1'b1;
        cfg_index      = reg_index;
        cfg_data       = value;
        @(negedge clk);
        cfg_write      = 1'b0;
    endtask

    function automatic stim_row_t cfg_row(input logic [ckc_pkg::CFG_IDX_W-1:0] reg_index,
                                          input logic [ckc_pkg::CFG_DATA_W-1:0] value);
        stim_row_t row_item;
        row_item = '{ROW_CFG, reg_index, value, '0, '0, '0, 1'b0, 1'b0, '0};
        return row_item;
    endfunction

    function automatic stim_row_t pix_row(input logic [ckc_pkg::PIX_W-1:0] b, g, r,
                                          input logic closes);
        stim_row_t row_item;
        row_item = '{ROW_PIX, '0, '0, b, g, r, closes, 1'b0, '0};
        return row_item;
    endfunction

    // Closing pixel whose result word is typed in.
    function automatic stim_row_t pinned_row(input logic [ckc_pkg::PIX_W-1:0] b, g, r,
                                             input centroid_t want);
        stim_row_t row_item;
        row_item = '{ROW_PIX, '0, '0, b, g, r, 1'b1, 1'b1, want};
        return row_item;
    endfunction

    initial
    begin
        logic [ckc_pkg::BOUND_W-1:0] band_lo;
        logic [ckc_pkg::BOUND_W-1:0] band_hi;
        logic [ckc_pkg::PIX_W-1:0]   lvl_a;
        logic [ckc_pkg::PIX_W-1:0]   lvl_b;
        logic [ckc_pkg::PIX_W-1:0]   swap;
        int                          ch;
        int                          random_pixels;
        int                          regions;
        int                          region_len;

        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        pixel_ch.valid      = 1'b0;
        pixel_ch.blue       = '0;
        pixel_ch.green      = '0;
        pixel_ch.red        = '0;
        pixel_ch.last_pixel = 1'b0;
        result_ch.ready     = 1'b0;
        random_pixels       = 0;

        // Defaults after reset: full band, width 640, no threshold, origin 0.
        directed_rows.push_back(pinned_row(8'h00, 8'h00, 8'h00, '{1'b1, 13'd0, 14'd22, 25'd1}));
        directed_rows.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, 1'b0));
        directed_rows.push_back(pinned_row(8'hFF, 8'hFF, 8'hFF, '{1'b1, 13'd0, 14'd22, 25'd2}));
        // Narrow band; bit 24 of the lower bound write is junk and must be masked.
        directed_rows.push_back(cfg_row(ckc_pkg::REG_LOWER_BOUND, 25'h110_2030));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_UPPER_BOUND, 25'h040_5060));
        directed_rows.push_back(pix_row(8'h30, 8'h20, 8'h10, 1'b0));  // on the lower bound
        directed_rows.push_back(pix_row(8'h60, 8'h50, 8'h40, 1'b0));  // on the upper bound
        directed_rows.push_back(pix_row(8'h2F, 8'h20, 8'h10, 1'b0));  // blue one below
        directed_rows.push_back(pix_row(8'h60, 8'h50, 8'h41, 1'b0));  // red one above
        directed_rows.push_back(pix_row(8'h45, 8'h35, 8'h25, 1'b1));
        // Threshold and far origin, two-pixel rows.
        directed_rows.push_back(cfg_row(ckc_pkg::REG_MIN_COUNT, 25'd2));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_ORIGIN_X, 25'd4095));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_ORIGIN_Y, 25'd4095));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_REGION_WIDTH, 25'd2));
        directed_rows.push_back(pix_row(8'h40, 8'h30, 8'h20, 1'b0));
        directed_rows.push_back(pix_row(8'h00, 8'h00, 8'h00, 1'b0));
        // Count equal to the threshold is not found.
        directed_rows.push_back(pinned_row(8'h40, 8'h30, 8'h20, '{1'b0, 13'd0, 14'd0, 25'd2}));
        directed_rows.push_back(pix_row(8'h40, 8'h30, 8'h20, 1'b0));
        directed_rows.push_back(pix_row(8'h40, 8'h30, 8'h20, 1'b0));
        directed_rows.push_back(pix_row(8'h40, 8'h30, 8'h20, 1'b1));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_MIN_COUNT, 25'd16777216));
        directed_rows.push_back(pinned_row(8'h40, 8'h30, 8'h20, '{1'b0, 13'd0, 14'd0, 25'd1}));
        // Inverted bounds: nothing matches, not even with a zero threshold.
        directed_rows.push_back(cfg_row(ckc_pkg::REG_MIN_COUNT, 25'd0));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_LOWER_BOUND, 25'hFF_FFFF));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_UPPER_BOUND, 25'h100_0000));
        directed_rows.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, 1'b0));
        directed_rows.push_back(pinned_row(8'h00, 8'h00, 8'h00, '{1'b0, 13'd0, 14'd0, 25'd0}));
        // Width 0 acts as 1; writes to unused indexes change nothing.
        directed_rows.push_back(cfg_row(ckc_pkg::REG_REGION_WIDTH, 25'd0));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_LOWER_BOUND, 25'd0));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_UPPER_BOUND, 25'hFF_FFFF));
        directed_rows.push_back(cfg_row(REG_SPARE_A, 25'h1FF_FFFF));
        directed_rows.push_back(cfg_row(REG_SPARE_B, 25'h1FF_FFFF));
        directed_rows.push_back(pix_row(8'h12, 8'h34, 8'h56, 1'b0));
        directed_rows.push_back(pix_row(8'h12, 8'h34, 8'h56, 1'b0));
        directed_rows.push_back(pix_row(8'h12, 8'h34, 8'h56, 1'b1));
        // Width past the maximum acts as the maximum; origin back to zero.
        directed_rows.push_back(cfg_row(ckc_pkg::REG_REGION_WIDTH, 25'd8191));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_ORIGIN_X, 25'd0));
        directed_rows.push_back(cfg_row(ckc_pkg::REG_ORIGIN_Y, 25'd0));
        directed_rows.push_back(pix_row(8'h00, 8'h00, 8'h00, 1'b0));
        directed_rows.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, 1'b1));

        // Hold reset, then release it on a falling edge.
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        ready_mode = READY_DITHER;
        gap_limit  = 3;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                settle_block();
                write_reg(directed_rows[i].reg_index, directed_rows[i].value);
            end
            else
                send_pixel(directed_rows[i].blue, directed_rows[i].green, directed_rows[i].red,
                           directed_rows[i].closes, directed_rows[i].pinned,
                           directed_rows[i].want);
        end

        // One-column region: every pixel starts a new row.
        settle_block();
        write_reg(ckc_pkg::REG_REGION_WIDTH, 25'd1);
        ready_mode = READY_ALWAYS;
        gap_limit  = 0;
        send_region(40);

        // Full-width region with the origin at its far corner.
        settle_block();
        write_reg(ckc_pkg::REG_REGION_WIDTH, 25'd4096);
        write_reg(ckc_pkg::REG_ORIGIN_X, 25'd4095);
        write_reg(ckc_pkg::REG_ORIGIN_Y, 25'd4095);
        ready_mode = READY_SPARSE;
        gap_limit  = 2;
        send_region(100);

        // Random phases: fresh settings while idle, then a handful of regions.
        while (random_pixels < RANDOM_PIXELS)
        begin
            settle_block();

            band_lo = '0;
            band_hi = '0;
            for (ch = 0; ch < 3; ch++)
            begin
                lvl_a = ckc_pkg::PIX_W'($urandom);
                lvl_b = ckc_pkg::PIX_W'($urandom);
                if (lvl_a > lvl_b)
                begin
                    swap  = lvl_a;
                    lvl_a = lvl_b;
                    lvl_b = swap;
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    lvl_a = 8'h00;
                    lvl_b = 8'hFF;
                end
                band_lo[ch*8 +: 8] = lvl_a;
                band_hi[ch*8 +: 8] = lvl_b;
            end
            // Now and then swap one channel's bounds so that no pixel can match unless they are equal.
            if ($urandom_range(0, 9) == 0)
            begin
                ch = $urandom_range(0, 2);
                swap = band_lo[ch*8 +: 8];
                band_lo[ch*8 +: 8] = band_hi[ch*8 +: 8];
                band_hi[ch*8 +: 8] = swap;
            end
            write_reg(ckc_pkg::REG_LOWER_BOUND, {1'($urandom), band_lo});
            write_reg(ckc_pkg::REG_UPPER_BOUND, {1'($urandom), band_hi});

            case ($urandom_range(0, 9))
                0:       write_reg(ckc_pkg::REG_MIN_COUNT, 25'd16777216);
                1:       write_reg(ckc_pkg::REG_MIN_COUNT, ckc_pkg::CFG_DATA_W'($urandom));
                default: write_reg(ckc_pkg::REG_MIN_COUNT,
                                   ckc_pkg::CFG_DATA_W'($urandom_range(0, 6)));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(ckc_pkg::REG_ORIGIN_X, 25'd0);
                1:       write_reg(ckc_pkg::REG_ORIGIN_X, 25'd4095);
                default: write_reg(ckc_pkg::REG_ORIGIN_X,
                                   ckc_pkg::CFG_DATA_W'($urandom));  // upper bits masked
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(ckc_pkg::REG_ORIGIN_Y, 25'd0);
                1:       write_reg(ckc_pkg::REG_ORIGIN_Y, 25'd4095);
                default: write_reg(ckc_pkg::REG_ORIGIN_Y, ckc_pkg::CFG_DATA_W'($urandom));
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(ckc_pkg::REG_REGION_WIDTH, 25'd0);
                1:       write_reg(ckc_pkg::REG_REGION_WIDTH, 25'd4096);
                2:       write_reg(ckc_pkg::REG_REGION_WIDTH,
                                   ckc_pkg::CFG_DATA_W'($urandom_range(4097, 8191)));
                default: write_reg(ckc_pkg::REG_REGION_WIDTH,
                                   ckc_pkg::CFG_DATA_W'($urandom_range(1, 12)));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          ckc_pkg::CFG_DATA_W'($urandom));

            ready_mode = ready_mode_t'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0, 1:    gap_limit = 0;
                2:       gap_limit = 2;
                default: gap_limit = 6;
            endcase

            regions = $urandom_range(1, 8);
            repeat (regions)
            begin
                case ($urandom_range(0, 9))
                    0:       region_len = 1;
                    1:       region_len = $urandom_range(40, 160);
                    default: region_len = $urandom_range(2, 24);
                endcase
                send_region(region_len);
                random_pixels += region_len;
            end
        end

        // Drain everything, then give the verdict.
        settle_block();
        if (mismatches == 0 && pending_centroids.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
